### hw/rtl/hag_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hag_pkg
// Shared types, codes and constants of the hyperslab address generator.
// ----------------------------------------------------------------------------
package hag_pkg;

  // Default sizes handed to the top level parameters
  localparam int MAX_DIMS_DEF    = 8;
  localparam int INDEX_BITS_DEF  = 16;
  localparam int OFFSET_BITS_DEF = 48;

  // Fixed field widths
  localparam int REQ_W       = 2;
  localparam int DIM_INDEX_W = 3;
  localparam int STATUS_W    = 2;
  localparam int BPI_W       = 13;
  localparam int DIMCNT_W    = 4;

  // Configuration port
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;
  localparam int REG_IDX_W  = 2;

  // Digit width of the shared multiplier
  localparam int DIGIT_W = 16;

  typedef enum logic [REQ_W-1:0] {
    REQ_LOAD    = 2'd0,
    REQ_START   = 2'd1,
    REQ_ADVANCE = 2'd2
  } req_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK       = 2'd0,
    STAT_BAD_DESC = 2'd1,
    STAT_NO_WALK  = 2'd2
  } status_t;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_MAJOR_ORDER    = 2'd0,
    REG_BYTES_PER_ITEM = 2'd1,
    REG_DIM_COUNT      = 2'd2
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_STRIDE,
    ST_STRIDE_WAIT,
    ST_SUM,
    ST_SUM_WAIT,
    ST_ODO,
    ST_EMIT
  } state_t;

  // Register contents plus a strobe for any write that hits a register
  typedef struct packed {
    logic                major_order;
    logic [BPI_W-1:0]    bytes_per_item;
    logic [DIMCNT_W-1:0] dim_count;
    logic                wr_hit;
  } cfg_t;

endpackage

### hw/rtl/hyperslab_address_generator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hyperslab_address_generator_core
// Byte address walker for a strided multi-dimensional sub-array.
// ----------------------------------------------------------------------------
// Load requests store a (start, stop, step, extent) descriptor per dimension;
// a start request checks the descriptors, builds byte strides one dimension
// at a time and opens a walk; each advance returns the strided and packed
// byte offsets of the current element and steps the index odometer, with the
// last used dimension varying fastest. All products run through a single
// multiply-accumulate unit that takes its index operand as D =
// ceil(INDEX_BITS/16) digits of 16 bits. A start checks each used
// dimension, then multiplies out the strides; an advance sums one product per
// dimension, then steps the odometer from the innermost dimension out. The
// input is stalled while a request is in work; a finished result waits in
// the output register and does not block the next request from starting.
// ----------------------------------------------------------------------------
module hyperslab_address_generator_core
  import hag_pkg::*;
#(
  parameter int MAX_DIMS    = MAX_DIMS_DEF,
  parameter int INDEX_BITS  = INDEX_BITS_DEF,
  parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // request channel
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [REQ_W-1:0]       in_req_type,
  input  logic [DIM_INDEX_W-1:0] in_dim_index,
  input  logic [INDEX_BITS-1:0]  in_range_start,
  input  logic [INDEX_BITS-1:0]  in_range_stop,
  input  logic [INDEX_BITS-1:0]  in_range_step,
  input  logic [INDEX_BITS-1:0]  in_dim_extent,
  // result channel
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [OFFSET_BITS-1:0] out_strided_offset,
  output logic [OFFSET_BITS-1:0] out_packed_offset,
  output logic                   out_last_element,
  output logic [STATUS_W-1:0]    out_status,
  // configuration port
  input  logic                   cfg_psel,
  input  logic                   cfg_penable,
  input  logic                   cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [CFG_DATA_W-1:0]  cfg_pwdata,
  output logic [CFG_DATA_W-1:0]  cfg_prdata,
  output logic                   cfg_pready
);

  localparam int DIM_W = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam logic [DIM_W-1:0] MAX_LAST = DIM_W'(MAX_DIMS - 1);

  cfg_t cfg;

  // descriptor and walk tables, one entry read per cycle at dim_r
  logic [INDEX_BITS-1:0]  start_tbl_r  [MAX_DIMS];
  logic [INDEX_BITS-1:0]  stop_tbl_r   [MAX_DIMS];
  logic [INDEX_BITS-1:0]  step_tbl_r   [MAX_DIMS];
  logic [INDEX_BITS-1:0]  ext_tbl_r    [MAX_DIMS];
  logic [OFFSET_BITS-1:0] stride_tbl_r [MAX_DIMS];
  logic [INDEX_BITS-1:0]  cur_tbl_r    [MAX_DIMS];

  state_t                 state_r, state_nxt;
  logic [DIM_W-1:0]       dim_r, dim_nxt;
  logic                   walk_active_r, walk_active_nxt;
  logic [OFFSET_BITS-1:0] sum_r, sum_nxt;
  logic [OFFSET_BITS-1:0] pack_r, pack_nxt;
  logic [OFFSET_BITS-1:0] res_so_r, res_so_nxt;
  logic [OFFSET_BITS-1:0] res_po_r, res_po_nxt;
  logic                   res_last_r, res_last_nxt;
  status_t                res_status_r, res_status_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [OFFSET_BITS-1:0] out_so_r, out_so_nxt;
  logic [OFFSET_BITS-1:0] out_po_r, out_po_nxt;
  logic                   out_last_r, out_last_nxt;
  status_t                out_status_r, out_status_nxt;

  logic                   load_we;
  logic                   cur_we;
  logic [INDEX_BITS-1:0]  cur_wdata;
  logic                   stride_we;
  logic [DIM_W-1:0]       stride_waddr;
  logic [OFFSET_BITS-1:0] stride_wdata;

  logic                   mul_start;
  logic [INDEX_BITS-1:0]  mul_b;
  logic [OFFSET_BITS-1:0] mul_acc;
  logic                   mul_done;
  logic [OFFSET_BITS-1:0] mul_result;

  logic [INDEX_BITS-1:0]  rd_start, rd_stop, rd_step, rd_ext, rd_cur;
  logic [OFFSET_BITS-1:0] rd_stride;
  logic                   rd_bad;
  logic                   in_bad;
  logic                   can_step;
  logic                   in_accept;
  logic                   out_free;
  logic                   dim_ok;
  logic [DIM_W-1:0]       last_dim;
  logic [DIM_W-1:0]       load_addr;
  logic [OFFSET_BITS-1:0] bpi_ext;
  req_t                   req;

  hag_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  hag_mul #(
    .INDEX_BITS  (INDEX_BITS),
    .OFFSET_BITS (OFFSET_BITS)
  ) u_mul (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (mul_start),
    .a      (rd_stride),
    .b      (mul_b),
    .acc_in (mul_acc),
    .done   (mul_done),
    .result (mul_result)
  );

  assign rd_start  = start_tbl_r[dim_r];
  assign rd_stop   = stop_tbl_r[dim_r];
  assign rd_step   = step_tbl_r[dim_r];
  assign rd_ext    = ext_tbl_r[dim_r];
  assign rd_cur    = cur_tbl_r[dim_r];
  assign rd_stride = stride_tbl_r[dim_r];

  assign rd_bad   = (rd_step == '0) || (rd_start > rd_stop);
  assign in_bad   = (in_range_step == '0) || (in_range_start > in_range_stop);
  assign can_step = (rd_stop >= rd_cur) && ((rd_stop - rd_cur) >= rd_step) &&
                    (rd_step != '0);

  assign in_stall  = (state_r != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign req       = req_t'(in_req_type);
  assign bpi_ext   = OFFSET_BITS'(cfg.bytes_per_item);
  assign dim_ok    = (32'(in_dim_index) < MAX_DIMS);
  assign load_addr = DIM_W'(in_dim_index);

  // clamp the dimension count into 1..MAX_DIMS, kept as the last index
  assign last_dim = (cfg.dim_count == '0) ? '0 :
                    ({1'b0, cfg.dim_count} > 5'(MAX_DIMS)) ? MAX_LAST :
                    DIM_W'(cfg.dim_count - DIMCNT_W'(1));

  assign mul_b   = (state_r == ST_SUM) ? rd_cur : rd_ext;
  assign mul_acc = (state_r == ST_SUM) ? sum_r : '0;

  always_comb begin
    state_nxt       = state_r;
    dim_nxt         = dim_r;
    walk_active_nxt = walk_active_r;
    sum_nxt         = sum_r;
    pack_nxt        = pack_r;
    res_so_nxt      = res_so_r;
    res_po_nxt      = res_po_r;
    res_last_nxt    = res_last_r;
    res_status_nxt  = res_status_r;
    out_valid_nxt   = out_valid_r && out_stall;
    out_so_nxt      = out_so_r;
    out_po_nxt      = out_po_r;
    out_last_nxt    = out_last_r;
    out_status_nxt  = out_status_r;
    load_we         = 1'b0;
    cur_we          = 1'b0;
    cur_wdata       = rd_start;
    stride_we       = 1'b0;
    stride_waddr    = dim_r;
    stride_wdata    = bpi_ext;
    mul_start       = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          res_so_nxt   = '0;
          res_po_nxt   = '0;
          res_last_nxt = 1'b0;
          unique case (req)
            REQ_LOAD: begin
              load_we         = dim_ok;
              walk_active_nxt = 1'b0;
              res_status_nxt  = in_bad ? STAT_BAD_DESC : STAT_OK;
              state_nxt       = ST_EMIT;
            end
            REQ_START: begin
              walk_active_nxt = 1'b0;
              dim_nxt         = '0;
              state_nxt       = ST_CHECK;
            end
            default: begin
              // advance, and the spare code acts the same
              if (!walk_active_r) begin
                res_status_nxt = STAT_NO_WALK;
                state_nxt      = ST_EMIT;
              end else begin
                dim_nxt   = '0;
                sum_nxt   = '0;
                state_nxt = ST_SUM;
              end
            end
          endcase
        end
      end

      ST_CHECK: begin
        if (rd_bad) begin
          res_status_nxt = STAT_BAD_DESC;
          state_nxt      = ST_EMIT;
        end else begin
          cur_we = 1'b1;
          if (dim_r == last_dim) begin
            // seed the stride chain with the item size, at 0 or at last_dim
            stride_we    = 1'b1;
            stride_waddr = cfg.major_order ? '0 : last_dim;
            if (last_dim == '0) begin
              walk_active_nxt = 1'b1;
              pack_nxt        = '0;
              res_status_nxt  = STAT_OK;
              state_nxt       = ST_EMIT;
            end else begin
              dim_nxt   = cfg.major_order ? '0 : last_dim;
              state_nxt = ST_STRIDE;
            end
          end else begin
            dim_nxt = dim_r + DIM_W'(1);
          end
        end
      end

      ST_STRIDE: begin
        mul_start = 1'b1;
        state_nxt = ST_STRIDE_WAIT;
      end

      ST_STRIDE_WAIT: begin
        if (mul_done) begin
          stride_we    = 1'b1;
          stride_waddr = cfg.major_order ? dim_r + DIM_W'(1) : dim_r - DIM_W'(1);
          stride_wdata = mul_result;
          dim_nxt      = stride_waddr;
          if (cfg.major_order ? (stride_waddr == last_dim) : (stride_waddr == '0)) begin
            walk_active_nxt = 1'b1;
            pack_nxt        = '0;
            res_status_nxt  = STAT_OK;
            state_nxt       = ST_EMIT;
          end else begin
            state_nxt = ST_STRIDE;
          end
        end
      end

      ST_SUM: begin
        mul_start = 1'b1;
        state_nxt = ST_SUM_WAIT;
      end

      ST_SUM_WAIT: begin
        if (mul_done) begin
          sum_nxt = mul_result;
          if (dim_r == last_dim) begin
            state_nxt = ST_ODO;
          end else begin
            dim_nxt   = dim_r + DIM_W'(1);
            state_nxt = ST_SUM;
          end
        end
      end

      ST_ODO: begin
        // step the innermost dimension that has room, reset the ones passed
        cur_we = 1'b1;
        if (can_step || (dim_r == '0)) begin
          cur_wdata      = can_step ? rd_cur + rd_step : rd_start;
          res_so_nxt     = sum_r;
          res_po_nxt     = pack_r;
          res_last_nxt   = !can_step;
          res_status_nxt = STAT_OK;
          pack_nxt       = pack_r + bpi_ext;
          if (!can_step) begin
            walk_active_nxt = 1'b0;
          end
          state_nxt = ST_EMIT;
        end else begin
          dim_nxt = dim_r - DIM_W'(1);
        end
      end

      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_so_nxt     = res_so_r;
          out_po_nxt     = res_po_r;
          out_last_nxt   = res_last_r;
          out_status_nxt = res_status_r;
          state_nxt      = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // any register write closes the walk
    if (cfg.wr_hit) begin
      walk_active_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      walk_active_r <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      walk_active_r <= walk_active_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dim_r        <= dim_nxt;
    sum_r        <= sum_nxt;
    pack_r       <= pack_nxt;
    res_so_r     <= res_so_nxt;
    res_po_r     <= res_po_nxt;
    res_last_r   <= res_last_nxt;
    res_status_r <= res_status_nxt;
    out_so_r     <= out_so_nxt;
    out_po_r     <= out_po_nxt;
    out_last_r   <= out_last_nxt;
    out_status_r <= out_status_nxt;
  end

  always_ff @(posedge clk) begin
    if (load_we) begin
      start_tbl_r[load_addr] <= in_range_start;
      stop_tbl_r[load_addr]  <= in_range_stop;
      step_tbl_r[load_addr]  <= in_range_step;
      ext_tbl_r[load_addr]   <= in_dim_extent;
    end
    if (cur_we) begin
      cur_tbl_r[dim_r] <= cur_wdata;
    end
    if (stride_we) begin
      stride_tbl_r[stride_waddr] <= stride_wdata;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_strided_offset = out_so_r;
  assign out_packed_offset  = out_po_r;
  assign out_last_element   = out_last_r;
  assign out_status         = out_status_r;

`ifndef ASSERT_OFF
  a_mul_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    mul_done |-> (state_r == ST_STRIDE_WAIT || state_r == ST_SUM_WAIT))
    else $error("multiplier finished outside a wait state");

  a_last_is_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_last_r) |-> (out_status_r == STAT_OK))
    else $error("last element flagged on a failed request");

  a_out_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == ST_EMIT))
    else $error("result presented without passing the emit state");
`endif

endmodule

### hw/rtl/hag_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hag_cfg
// APB-style register block: major order, item size and dimension count.
// ----------------------------------------------------------------------------
module hag_cfg
  import hag_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg
);

  logic                major_order_r, major_order_nxt;
  logic [BPI_W-1:0]    bpi_r, bpi_nxt;
  logic [DIMCNT_W-1:0] dim_count_r, dim_count_nxt;
  logic                wr_en;
  logic                wr_hit;
  reg_idx_t            reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = reg_idx_t'(paddr[CFG_ADDR_W-1:2]);

  always_comb begin
    major_order_nxt = major_order_r;
    bpi_nxt         = bpi_r;
    dim_count_nxt   = dim_count_r;
    wr_hit          = 1'b0;
    if (wr_en) begin
      unique case (reg_idx)
        REG_MAJOR_ORDER: begin
          major_order_nxt = pwdata[0];
          wr_hit          = 1'b1;
        end
        REG_BYTES_PER_ITEM: begin
          bpi_nxt = pwdata[BPI_W-1:0];
          wr_hit  = 1'b1;
        end
        REG_DIM_COUNT: begin
          dim_count_nxt = pwdata[DIMCNT_W-1:0];
          wr_hit        = 1'b1;
        end
        default: begin
          wr_hit = 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_MAJOR_ORDER:    prdata = CFG_DATA_W'(major_order_r);
      REG_BYTES_PER_ITEM: prdata = CFG_DATA_W'(bpi_r);
      REG_DIM_COUNT:      prdata = CFG_DATA_W'(dim_count_r);
      default:            prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      major_order_r <= 1'b0;
      bpi_r         <= BPI_W'(1);
      dim_count_r   <= DIMCNT_W'(1);
    end else begin
      major_order_r <= major_order_nxt;
      bpi_r         <= bpi_nxt;
      dim_count_r   <= dim_count_nxt;
    end
  end

  assign cfg.major_order    = major_order_r;
  assign cfg.bytes_per_item = bpi_r;
  assign cfg.dim_count      = dim_count_r;
  assign cfg.wr_hit         = wr_hit;

endmodule

### hw/rtl/hag_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hag_mul
// Shared multiply-accumulate unit: result = acc_in + a * b, modulo the
// offset width. b is consumed one 16-bit digit per cycle.
// ----------------------------------------------------------------------------
module hag_mul
  import hag_pkg::*;
#(
  parameter int INDEX_BITS  = INDEX_BITS_DEF,
  parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [OFFSET_BITS-1:0] a,
  input  logic [INDEX_BITS-1:0]  b,
  input  logic [OFFSET_BITS-1:0] acc_in,
  output logic                   done,
  output logic [OFFSET_BITS-1:0] result
);

  localparam int NDIG  = (INDEX_BITS + DIGIT_W - 1) / DIGIT_W;
  localparam int B_W   = NDIG * DIGIT_W;
  localparam int CNT_W = $clog2(NDIG + 1);

  logic [OFFSET_BITS-1:0]         a_r, a_nxt;
  logic [B_W-1:0]                 b_r, b_nxt;
  logic [OFFSET_BITS-1:0]         acc_r, acc_nxt;
  logic [OFFSET_BITS-1:0]         prod_r, prod_nxt;
  logic [CNT_W-1:0]               cnt_r, cnt_nxt;
  logic                           pvld_r, pvld_nxt;
  logic                           done_r, done_nxt;
  logic [OFFSET_BITS+DIGIT_W-1:0] full_prod;

  assign full_prod = a_r * b_r[DIGIT_W-1:0];

  always_comb begin
    a_nxt    = a_r;
    b_nxt    = b_r;
    acc_nxt  = acc_r;
    prod_nxt = prod_r;
    cnt_nxt  = cnt_r;
    pvld_nxt = 1'b0;
    done_nxt = pvld_r && (cnt_r == '0);
    if (pvld_r) begin
      acc_nxt = acc_r + prod_r;
    end
    if (start) begin
      a_nxt    = a;
      b_nxt    = B_W'(b);
      acc_nxt  = acc_in;
      cnt_nxt  = CNT_W'(NDIG);
      done_nxt = 1'b0;
    end else if (cnt_r != '0) begin
      // one digit per cycle; product is registered before the add
      prod_nxt = full_prod[OFFSET_BITS-1:0];
      pvld_nxt = 1'b1;
      a_nxt    = a_r << DIGIT_W;
      b_nxt    = b_r >> DIGIT_W;
      cnt_nxt  = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      pvld_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      pvld_r <= pvld_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r    <= a_nxt;
    b_r    <= b_nxt;
    acc_r  <= acc_nxt;
    prod_r <= prod_nxt;
  end

  assign done   = done_r;
  assign result = acc_r;

endmodule

### bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the hyperslab address generator core.
// ----------------------------------------------------------------------------
// A queue of requests feeds a clocked driver; every accepted request is run
// through a behavioral copy of the walker (descriptor tables, strides, index
// odometer) and its expected result is queued. A clocked monitor compares each
// result transfer field by field. Registers are rewritten over the APB-style
// port between phases, once the block has drained. Both sides idle in short
// random bursts, the receiver holds off once for a long stretch, and the last
// phase runs at full rate.
// ----------------------------------------------------------------------------
module tb_top;
  import hag_pkg::*;

  localparam int IDX_W = INDEX_BITS_DEF;
  localparam int OFS_W = OFFSET_BITS_DEF;
  localparam int NDIM  = MAX_DIMS_DEF;
  localparam logic [REQ_W-1:0] REQ_OTHER = 2'd3;  // decodes as advance
  localparam int TARGET_ITEMS = 550;
  localparam int DRAIN_CYCLES = 50;

  typedef struct packed {
    logic [REQ_W-1:0]       req;
    logic [DIM_INDEX_W-1:0] dim;
    logic [IDX_W-1:0]       lo;
    logic [IDX_W-1:0]       hi;
    logic [IDX_W-1:0]       step;
    logic [IDX_W-1:0]       extent;
  } hyper_req_t;

  typedef struct packed {
    logic [OFS_W-1:0]    strided;
    logic [OFS_W-1:0]    packed_off;
    logic                last_el;
    logic [STATUS_W-1:0] status;
  } addr_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic [REQ_W-1:0]       in_req_type = '0;
  logic [DIM_INDEX_W-1:0] in_dim_index = '0;
  logic [IDX_W-1:0]       in_range_start = '0;
  logic [IDX_W-1:0]       in_range_stop = '0;
  logic [IDX_W-1:0]       in_range_step = '0;
  logic [IDX_W-1:0]       in_dim_extent = '0;

  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [OFS_W-1:0]       out_strided_offset;
  logic [OFS_W-1:0]       out_packed_offset;
  logic                   out_last_element;
  logic [STATUS_W-1:0]    out_status;

  logic                   cfg_psel = 1'b0;
  logic                   cfg_penable = 1'b0;
  logic                   cfg_pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0]  cfg_paddr = '0;
  logic [CFG_DATA_W-1:0]  cfg_pwdata = '0;
  logic [CFG_DATA_W-1:0]  cfg_prdata;
  logic                   cfg_pready;

  hyperslab_address_generator_core uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_req_type(in_req_type), .in_dim_index(in_dim_index),
    .in_range_start(in_range_start), .in_range_stop(in_range_stop),
    .in_range_step(in_range_step), .in_dim_extent(in_dim_extent),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_strided_offset(out_strided_offset), .out_packed_offset(out_packed_offset),
    .out_last_element(out_last_element), .out_status(out_status),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata),
    .cfg_prdata(cfg_prdata), .cfg_pready(cfg_pready)
  );

  always #6 clk = ~clk;

  // Walker copy: registers, descriptor tables and walk state
  logic             order_col = 1'b0;
  logic [BPI_W-1:0] item_bytes = 13'd1;
  logic [DIMCNT_W-1:0] dims_cfg = 4'd1;
  logic [IDX_W-1:0] lo_tab[NDIM], hi_tab[NDIM], step_tab[NDIM], ext_tab[NDIM];
  logic [IDX_W-1:0] idx_tab[NDIM];
  logic [OFS_W-1:0] stride_tab[NDIM];
  logic [OFS_W-1:0] elem_count = '0;
  logic             walking = 1'b0;

  addr_result_t expected_addr_q[$];
  hyper_req_t   send_q[$];

  int  errors = 0;
  int  pushed = 0;
  int  results_seen = 0;
  bit  calm = 1'b0;

  // Stimulus side view of the descriptors, updated as requests are queued
  int g_lo[NDIM], g_hi[NDIM], g_step[NDIM];
  int g_dims = 1;

  function automatic int used_dims(input logic [DIMCNT_W-1:0] cnt);
    if (cnt == 0) return 1;
    if (cnt > NDIM) return NDIM;
    return int'(cnt);
  endfunction

  task automatic hyperslab_predict(input hyper_req_t r);
    addr_result_t res;
    int n;
    logic [OFS_W-1:0] prod;
    logic bad;
    logic carried;
    n = used_dims(dims_cfg);
    res = '0;
    if (r.req == REQ_LOAD) begin
      lo_tab[r.dim] = r.lo;
      hi_tab[r.dim] = r.hi;
      step_tab[r.dim] = r.step;
      ext_tab[r.dim] = r.extent;
      walking = 1'b0;
      res.status = (r.step == 0 || r.lo > r.hi) ? STAT_BAD_DESC : STAT_OK;
    end else if (r.req == REQ_START) begin
      walking = 1'b0;
      bad = 1'b0;
      for (int d = 0; d < n; d++)
        if (step_tab[d] == 0 || lo_tab[d] > hi_tab[d]) bad = 1'b1;
      if (bad) begin
        res.status = STAT_BAD_DESC;
      end else begin
        for (int d = 0; d < n; d++) begin
          prod = 1;
          for (int k = (order_col ? 0 : d + 1); k < (order_col ? d : n); k++)
            prod = prod * ext_tab[k];
          stride_tab[d] = prod * item_bytes;
          idx_tab[d] = lo_tab[d];
        end
        elem_count = '0;
        walking = 1'b1;
        res.status = STAT_OK;
      end
    end else if (!walking) begin
      res.status = STAT_NO_WALK;
    end else begin
      for (int d = 0; d < n; d++)
        res.strided = res.strided + stride_tab[d] * idx_tab[d];
      res.packed_off = elem_count * item_bytes;
      // step the innermost dimension, reload and carry on overflow
      carried = 1'b1;
      for (int d = n - 1; d >= 0; d--) begin
        if (carried) begin
          if (hi_tab[d] >= idx_tab[d] && (hi_tab[d] - idx_tab[d]) >= step_tab[d] &&
              step_tab[d] != 0) begin
            idx_tab[d] = idx_tab[d] + step_tab[d];
            carried = 1'b0;
          end else begin
            idx_tab[d] = lo_tab[d];
          end
        end
      end
      elem_count = elem_count + 1;
      res.last_el = carried;
      if (carried) walking = 1'b0;
      res.status = STAT_OK;
    end
    expected_addr_q.push_back(res);
  endtask

  // Driver: one request per transfer, random gaps outside the final phase
  hyper_req_t cur_req;
  bit item_held = 1'b0;
  int gap_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        hyperslab_predict(cur_req);
        item_held = 1'b0;
      end
      if (!(in_valid && in_stall)) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (!calm && $urandom_range(0, 7) == 0) begin
          gap_left = $urandom_range(1, 7) - 1;
          in_valid <= 1'b0;
        end else if (send_q.size() > 0) begin
          cur_req = send_q.pop_front();
          item_held = 1'b1;
          in_valid <= 1'b1;
          in_req_type <= cur_req.req;
          in_dim_index <= cur_req.dim;
          in_range_start <= cur_req.lo;
          in_range_stop <= cur_req.hi;
          in_range_step <= cur_req.step;
          in_dim_extent <= cur_req.extent;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each result transfer, stall in bursts, one long hold-off
  int  stall_left = 0;
  int  hold_left = 0;
  bit  hold_done = 1'b0;
  addr_result_t exp_res;
  logic stall_nxt;

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (expected_addr_q.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected result transfer: strided %h packed %h last %0d status %0d",
                     out_strided_offset, out_packed_offset, out_last_element, out_status);
        end else begin
          exp_res = expected_addr_q.pop_front();
          if (out_strided_offset !== exp_res.strided ||
              out_packed_offset !== exp_res.packed_off ||
              out_last_element !== exp_res.last_el || out_status !== exp_res.status) begin
            errors++;
            if (errors <= 10)
              $display("mismatch (exp/got): strided %h/%h packed %h/%h last %0d/%0d status %0d/%0d",
                       exp_res.strided, out_strided_offset, exp_res.packed_off,
                       out_packed_offset, exp_res.last_el, out_last_element,
                       exp_res.status, out_status);
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        stall_nxt = 1'b1;
      end else if (!hold_done && results_seen >= 120) begin
        // hold long enough for the block to back up into the request side
        hold_done = 1'b1;
        hold_left = 399;
        stall_nxt = 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        stall_nxt = 1'b1;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 7) - 1;
        stall_nxt = 1'b1;
      end else begin
        stall_nxt = 1'b0;
      end
      out_stall <= stall_nxt;
    end
  end

  task automatic cfg_write(input reg_idx_t ridx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {ridx, 2'b00};
    cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    case (ridx)
      REG_MAJOR_ORDER:    order_col = val[0];
      REG_BYTES_PER_ITEM: item_bytes = val[BPI_W-1:0];
      default:            dims_cfg = val[DIMCNT_W-1:0];
    endcase
    walking = 1'b0;
  endtask

  task automatic set_config(input int order, input int bpi, input int dims);
    cfg_write(REG_MAJOR_ORDER, ($urandom & ~32'h1) | order);
    cfg_write(REG_BYTES_PER_ITEM, ($urandom & ~32'h1FFF) | bpi);
    cfg_write(REG_DIM_COUNT, ($urandom & ~32'hF) | dims);
    g_dims = used_dims(dims[DIMCNT_W-1:0]);
  endtask

  task automatic push_item(input logic [REQ_W-1:0] req, input int dim, input int lo,
                           input int hi, input int step, input int ext);
    hyper_req_t x;
    x.req = req;
    x.dim = dim[DIM_INDEX_W-1:0];
    x.lo = lo[IDX_W-1:0];
    x.hi = hi[IDX_W-1:0];
    x.step = step[IDX_W-1:0];
    x.extent = ext[IDX_W-1:0];
    if (req == REQ_LOAD) begin
      g_lo[x.dim] = x.lo;
      g_hi[x.dim] = x.hi;
      g_step[x.dim] = x.step;
    end
    send_q.push_back(x);
    pushed++;
  endtask

  task automatic push_plain(input logic [REQ_W-1:0] req);
    push_item(req, $urandom, $urandom, $urandom, $urandom, $urandom);
  endtask

  function automatic int span_of(input int d);
    if (g_step[d] == 0 || g_lo[d] > g_hi[d]) return 0;
    return (g_hi[d] - g_lo[d]) / g_step[d] + 1;
  endfunction

  function automatic int rand_extent();
    case ($urandom_range(0, 3))
      0:       return $urandom_range(0, 15);
      1:       return $urandom_range(0, 1) ? 65535 : 0;
      default: return $urandom_range(0, 65535);
    endcase
  endfunction

  // Load a good descriptor that selects exactly cnt indices
  task automatic load_span(input int d, input int cnt);
    int maxstep, step, top, lo, room;
    maxstep = (cnt == 1) ? 65535 : 65535 / (cnt - 1);
    step = $urandom_range(0, 1) ? $urandom_range(1, (maxstep < 16) ? maxstep : 16)
                                : $urandom_range(1, maxstep);
    top = (cnt - 1) * step;
    lo = $urandom_range(0, 65535 - top);
    room = (step - 1 < 65535 - lo - top) ? step - 1 : 65535 - lo - top;
    push_item(REQ_LOAD, d, lo, lo + top + $urandom_range(0, room), step, rand_extent());
  endtask

  // Reload descriptors as needed, start a walk and step through it
  task automatic walk_set();
    int prod, cnt, n_adv, d, lo;
    prod = 1;
    for (int k = 0; k < g_dims; k++) begin
      cnt = span_of(k);
      if (cnt == 0 || cnt > 3 || prod * cnt > 24 || $urandom_range(0, 2) == 0) begin
        cnt = $urandom_range(1, 3);
        if (prod * cnt > 24) cnt = 1;
        load_span(k, cnt);
      end
      prod = prod * cnt;
    end
    if ($urandom_range(0, 7) == 0) begin
      // broken sequence: spoil one used descriptor before the start
      d = $urandom_range(0, g_dims - 1);
      if ($urandom_range(0, 1)) begin
        push_item(REQ_LOAD, d, $urandom, $urandom, 0, rand_extent());
      end else begin
        lo = $urandom_range(1, 65535);
        push_item(REQ_LOAD, d, lo, $urandom_range(0, lo - 1), $urandom_range(1, 65535),
                  rand_extent());
      end
      push_plain(REQ_START);
      push_plain(REQ_ADVANCE);
    end else begin
      push_plain(REQ_START);
      n_adv = prod;
      case ($urandom_range(0, 5))
        0: n_adv = $urandom_range(0, prod - 1);
        1: n_adv = prod + $urandom_range(1, 2);
        default: ;
      endcase
      for (int i = 0; i < n_adv; i++)
        push_plain(($urandom_range(0, 4) == 0) ? REQ_OTHER : REQ_ADVANCE);
    end
  endtask

  task automatic wait_idle();
    do @(posedge clk);
    while (send_q.size() != 0 || item_held || expected_addr_q.size() != 0);
  endtask

  int ph_order[4] = '{1, 0, 1, 0};
  int ph_bpi[4]   = '{8191, 0, 1, 4096};
  int ph_dims[4]  = '{8, 2, 0, 15};

  initial begin
    int phase, goal;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    set_config(0, 4, 3);

    // directed: no walk, every dimension loaded, a full walk, bad descriptors
    push_plain(REQ_ADVANCE);
    push_item(REQ_LOAD, 0, 1, 2, 1, 4);
    push_item(REQ_LOAD, 1, 0, 3, 3, 5);
    push_item(REQ_LOAD, 2, 2, 4, 2, 6);
    for (int d = 3; d < NDIM; d++) push_item(REQ_LOAD, d, 0, 65535, 65535, 65535);
    push_plain(REQ_START);
    for (int i = 0; i < 8; i++) push_plain((i == 5) ? REQ_OTHER : REQ_ADVANCE);
    push_plain(REQ_ADVANCE);
    push_item(REQ_LOAD, 1, 5, 9, 0, 0);
    push_plain(REQ_START);
    push_item(REQ_LOAD, 1, 9, 5, 1, 0);
    push_item(REQ_LOAD, 1, 0, 0, 1, 0);
    push_plain(REQ_START);
    push_plain(REQ_ADVANCE);

    phase = 0;
    while (pushed < TARGET_ITEMS) begin
      if (pushed >= TARGET_ITEMS - 70) calm = 1'b1;
      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clk);
      if (phase < 4)
        set_config(ph_order[phase], ph_bpi[phase], ph_dims[phase]);
      else
        set_config($urandom_range(0, 1),
                   $urandom_range(0, 1) ? $urandom_range(1, 16) : $urandom_range(0, 8191),
                   $urandom_range(0, 15));
      goal = (pushed + 70 < TARGET_ITEMS) ? pushed + 70 : TARGET_ITEMS;
      while (pushed < goal) begin
        if ($urandom_range(0, 6) == 0)
          push_plain(REQ_W'($urandom_range(0, 3)));
        else
          walk_set();
      end
      phase++;
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    #(5_000_000);
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

### filelist.f
hw/rtl/hag_pkg.sv
hw/rtl/hag_cfg.sv
hw/rtl/hag_mul.sv
hw/rtl/hyperslab_address_generator_core.sv
bench/tb_top.sv
